>>> src/utf8_stream_decoder_core_macros.svh
// Assertion helpers for the UTF-8 stream decoder.
`ifndef UTF8_STREAM_DECODER_CORE_MACROS_SVH
`define UTF8_STREAM_DECODER_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define USD_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define USD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/usd_pkg.sv
`default_nettype none

package usd_pkg;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned CpW      = 21;
  localparam int unsigned IdxOutW  = 24;
  localparam int unsigned IndexW   = 24;
  localparam int unsigned PendW    = 2;
  localparam int unsigned ContBits = 6;

  localparam logic [PendW-1:0] PendNone  = 2'd0;
  localparam logic [PendW-1:0] PendOne   = 2'd1;
  localparam logic [PendW-1:0] PendTwo   = 2'd2;
  localparam logic [PendW-1:0] PendThree = 2'd3;

  localparam logic [2:0] LeadTwoTag   = 3'b110;
  localparam logic [3:0] LeadThreeTag = 4'b1110;

  typedef logic [ByteW-1:0]   byte_t;
  typedef logic [CpW-1:0]     cp_t;
  typedef logic [PendW-1:0]   pend_t;
  typedef logic [IndexW-1:0]  index_t;
  typedef logic [IdxOutW-1:0] idx_out_t;

  typedef struct packed {
    logic emit;
    cp_t  codepoint;
    logic truncated;
    logic string_end;
  } result_t;

  typedef struct packed {
    cp_t   partial;
    pend_t pending;
  } seq_state_t;

endpackage

`default_nettype wire

>>> src/usd_if.sv
`default_nettype none

interface usd_in_if;
  logic          valid;
  logic          ready;
  usd_pkg::byte_t data_byte;
  logic          last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface usd_out_if;
  logic               valid;
  logic               ready;
  usd_pkg::cp_t       codepoint;
  usd_pkg::idx_out_t  codepoint_index;
  logic               truncated;
  logic               string_end;

  modport source (output valid, output codepoint, output codepoint_index,
                  output truncated, output string_end, input ready);
  modport sink (input valid, input codepoint, input codepoint_index,
                input truncated, input string_end, output ready);
endinterface

`default_nettype wire

>>> src/usd_decode.sv
`default_nettype none

module usd_decode (
  input  usd_pkg::byte_t     data_byte,
  input  logic               last_byte,
  input  usd_pkg::seq_state_t cur,
  output usd_pkg::seq_state_t nxt,
  output usd_pkg::result_t   res
);

  usd_pkg::seq_state_t upd;
  logic                done;
  usd_pkg::cp_t        padded;

  always_comb begin
    upd  = cur;
    done = 1'b0;
    if (cur.pending == usd_pkg::PendNone) begin
      if (!data_byte[7]) begin
        upd.partial = usd_pkg::CpW'(data_byte);
        done        = 1'b1;
      end else if (data_byte[7:5] == usd_pkg::LeadTwoTag) begin
        upd.partial = usd_pkg::CpW'(data_byte[4:0]);
        upd.pending = usd_pkg::PendOne;
      end else if (data_byte[7:4] == usd_pkg::LeadThreeTag) begin
        upd.partial = usd_pkg::CpW'(data_byte[3:0]);
        upd.pending = usd_pkg::PendTwo;
      end else begin
        upd.partial = usd_pkg::CpW'(data_byte[2:0]);
        upd.pending = usd_pkg::PendThree;
      end
    end else begin
      upd.partial = {cur.partial[usd_pkg::CpW-usd_pkg::ContBits-1:0],
                     data_byte[usd_pkg::ContBits-1:0]};
      upd.pending = cur.pending - usd_pkg::PendOne;
      done        = (upd.pending == usd_pkg::PendNone);
    end
  end

  // Missing continuation bytes of a cut-short sequence count as zero bits.
  always_comb begin
    unique case (upd.pending)
      usd_pkg::PendOne:   padded = upd.partial << 6;
      usd_pkg::PendTwo:   padded = upd.partial << 12;
      usd_pkg::PendThree: padded = upd.partial << 18;
      default:            padded = upd.partial;
    endcase
  end

  always_comb begin
    res.emit       = done || last_byte;
    res.codepoint  = done ? upd.partial : padded;
    res.truncated  = !done;
    res.string_end = last_byte;
    if (done || last_byte) begin
      nxt.partial = '0;
    end else begin
      nxt.partial = upd.partial;
    end
    nxt.pending = last_byte ? usd_pkg::PendNone : upd.pending;
  end

endmodule

`default_nettype wire

>>> src/usd_index.sv
`default_nettype none

module usd_index (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            tick,
  input  logic            clear,
  output usd_pkg::index_t count
);

  usd_pkg::index_t count_r;
  usd_pkg::index_t count_nxt;

  always_comb begin
    count_nxt = count_r;
    if (clear) begin
      count_nxt = '0;
    end else if (tick && (count_r != '1)) begin
      count_nxt = count_r + usd_pkg::IndexW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  assign count = count_r;

endmodule

`default_nettype wire

>>> src/utf8_stream_decoder_core.sv
// UTF-8 stream decoder.
// The in_ch channel takes one byte of a UTF-8 string per beat, with last_byte
// set on the final byte. The out_ch channel gives one beat per decoded
// codepoint, carrying the codepoint, its ordinal in the string (saturating),
// a truncated flag and a string_end flag on the beat caused by the last byte.
// A lead byte sets the sequence length and no validation is done; a string
// that ends inside a sequence gives a beat with the missing bits as zero.
// An accepted byte sits in an input register, is decoded by short logic
// against the sequence state, and any result is loaded into the output
// register that drives out_ch.valid. Throughput is one byte per cycle unless
// a stalled output register blocks a byte with a result; a byte that
// completes nothing does not use the output register at all.
// When the receiver stalls, the output register holds its beat, and the input
// register keeps taking bytes until it holds a byte that has a result to give.
// Synchronous reset clears both registers' valid flags, the partial sequence
// and the ordinal counter; the last byte of each string clears those two too.

`default_nettype none

`include "utf8_stream_decoder_core_macros.svh"

module utf8_stream_decoder_core (
  input  logic              clk,
  input  logic              rst_n,
  usd_in_if.sink            in_ch,
  usd_out_if.source         out_ch
);

  logic                stage_valid_r;
  usd_pkg::byte_t      stage_byte_r;
  logic                stage_last_r;
  usd_pkg::seq_state_t seq_r;
  usd_pkg::seq_state_t seq_nxt;
  usd_pkg::result_t    res;
  usd_pkg::index_t     count;
  logic                out_valid_r;
  usd_pkg::cp_t        out_cp_r;
  usd_pkg::idx_out_t   out_idx_r;
  logic                out_trunc_r;
  logic                out_end_r;
  logic                advance;
  logic                load_out;

  usd_decode u_decode (
    .data_byte (stage_byte_r),
    .last_byte (stage_last_r),
    .cur       (seq_r),
    .nxt       (seq_nxt),
    .res       (res)
  );

  usd_index u_index (
    .clk   (clk),
    .rst_n (rst_n),
    .tick  (load_out),
    .clear (advance && stage_last_r),
    .count (count)
  );

  assign advance  = stage_valid_r && (!res.emit || !out_valid_r || out_ch.ready);
  assign load_out = advance && res.emit;
  assign in_ch.ready = !stage_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      stage_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      stage_byte_r <= in_ch.data_byte;
      stage_last_r <= in_ch.last_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_r <= '0;
    end else if (advance) begin
      seq_r <= seq_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_cp_r    <= res.codepoint;
      out_idx_r   <= usd_pkg::IdxOutW'(count);
      out_trunc_r <= res.truncated;
      out_end_r   <= res.string_end;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.codepoint       = out_cp_r;
  assign out_ch.codepoint_index = out_idx_r;
  assign out_ch.truncated       = out_trunc_r;
  assign out_ch.string_end      = out_end_r;

  `USD_ASSERT_NEXT(a_stall_keeps_byte, stage_valid_r && !advance, stage_valid_r,
    "stalled byte was dropped from the input register")
  `USD_ASSERT_NEXT(a_last_clears_count, advance && stage_last_r, count == '0,
    "ordinal counter not cleared after the last byte")
  `USD_ASSERT_SAME(a_idle_seq_empty, seq_r.pending == usd_pkg::PendNone,
    seq_r.partial == '0, "partial bits left over with no sequence open")
  `USD_ASSERT_SAME(a_trunc_only_at_end, out_valid_r && out_trunc_r, out_end_r,
    "truncated beat without string end")

endmodule

`default_nettype wire
